// File: hw/rtl/tcc_pkg.sv
// Shared constants, codes and types of the text console cursor control.
package tcc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CELL_BASE_DEF  = 8;

  localparam int SCREEN_BITS   = 12;
  localparam int COLOR_BITS    = 24;
  localparam int CHAR_BITS     = 8;
  localparam int STREAM_BITS   = 2;
  localparam int SCALE_BITS    = 5;
  localparam int ROWS_BITS     = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam int SCALE_MAX  = 16;
  localparam int ROWS_MAX   = 255;
  localparam int TAB_SPACES = 4;
  localparam int CNT_BITS   = $clog2(TAB_SPACES);

  localparam logic [CHAR_BITS-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_BITS-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;

  localparam logic [STREAM_BITS-1:0] STREAM_OUT = 2'd0;
  localparam logic [STREAM_BITS-1:0] STREAM_ERR = 2'd1;

  localparam logic [COLOR_BITS-1:0] RED_INK = 24'hFF0000;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_INK    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAPER  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [COLOR_BITS-1:0]  ink_color;
    logic [COLOR_BITS-1:0]  paper_color;
    logic [SCALE_BITS-1:0]  glyph_scale;
    logic [SCREEN_BITS-1:0] screen_width;
    logic [SCREEN_BITS-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic                   command_kind;
    logic [CHAR_BITS-1:0]   glyph_code;
    logic [SCREEN_BITS-1:0] cell_x;
    logic [SCREEN_BITS-1:0] cell_y;
    logic [COLOR_BITS-1:0]  draw_color;
    logic [ROWS_BITS-1:0]   scroll_rows;
    logic                   last;
  } cmd_t;

endpackage

// File: hw/rtl/tcc_if.sv
// Request channels of the text console cursor control: characters, commands, configuration.
interface tcc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [1:0] stream_select;

  modport source (output valid, output char_code, output stream_select, input ready);
  modport sink (input valid, input char_code, input stream_select, output ready);
endinterface

interface tcc_cmd_if;
  logic        valid;
  logic        ready;
  logic        command_kind;
  logic [7:0]  glyph_code;
  logic [11:0] cell_x;
  logic [11:0] cell_y;
  logic [23:0] draw_color;
  logic [7:0]  scroll_rows;
  logic        last;

  modport source (output valid, output command_kind, output glyph_code, output cell_x,
                  output cell_y, output draw_color, output scroll_rows, output last,
                  input ready);
  modport sink (input valid, input command_kind, input glyph_code, input cell_x,
                input cell_y, input draw_color, input scroll_rows, input last,
                output ready);
endinterface

interface tcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/text_console_cursor_control.sv
// Top level of the text console cursor control: registers, sequencer and command output stage.
//
//   channel  modport  carries
//   char_i   sink     char_code, stream_select
//   cmd_o    source   command_kind, glyph_code, cell_x, cell_y, draw_color, scroll_rows, last
//   cfg_i    sink     index, data (always ready)
//
// A glyph passes S_ADV1 to S_ADV3 once taken, a tab does so once per space, a backspace
// passes S_BS_X and from column 0 the divider, and a newline S_NL1 to S_NL3, then S_NL4 or
// a scroll; the cursor arithmetic shares the single adder, and output stalls hold the sequencer.
// A backspace from column 0 below the top row runs a 12-step remainder of screen width by cell size.
// Reset clears the cursor and loads the register defaults. The output register lets the
// next character be taken while the last command still waits.
module text_console_cursor_control #(
  parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
  parameter int CELL_BASE  = tcc_pkg::CELL_BASE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_char_if.sink  char_i,
  tcc_cmd_if.source cmd_o,
  tcc_cfg_if.sink   cfg_i
);
  import tcc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_q;
  cmd_t emit_cmd;
  logic out_valid_q;
  logic emit_valid;
  logic emit_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ink_color     <= 24'hFFFFFF;
      cfg_q.paper_color   <= '0;
      cfg_q.glyph_scale   <= SCALE_BITS'(1);
      cfg_q.screen_width  <= SCREEN_BITS'(1024);
      cfg_q.screen_height <= SCREEN_BITS'(768);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_INK:    cfg_q.ink_color     <= cfg_i.data[COLOR_BITS-1:0];
        REG_PAPER:  cfg_q.paper_color   <= cfg_i.data[COLOR_BITS-1:0];
        REG_SCALE:  cfg_q.glyph_scale   <= cfg_i.data[SCALE_BITS-1:0];
        REG_WIDTH:  cfg_q.screen_width  <= cfg_i.data[SCREEN_BITS-1:0];
        REG_HEIGHT: cfg_q.screen_height <= cfg_i.data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  tcc_seq #(
    .COORD_BITS (COORD_BITS),
    .CELL_BASE  (CELL_BASE)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (char_i.valid),
    .in_ready_o      (char_i.ready),
    .char_code_i     (char_i.char_code),
    .stream_select_i (char_i.stream_select),
    .cfg_i           (cfg_q),
    .emit_valid_o    (emit_valid),
    .emit_ready_i    (emit_ready),
    .emit_o          (emit_cmd)
  );

  assign emit_ready = !out_valid_q || cmd_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      cmd_q <= emit_cmd;
    end
  end

  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.command_kind = cmd_q.command_kind;
  assign cmd_o.glyph_code   = cmd_q.glyph_code;
  assign cmd_o.cell_x       = cmd_q.cell_x;
  assign cmd_o.cell_y       = cmd_q.cell_y;
  assign cmd_o.draw_color   = cmd_q.draw_color;
  assign cmd_o.scroll_rows  = cmd_q.scroll_rows;
  assign cmd_o.last         = cmd_q.last;

`ifndef SYNTHESIS
  a_ready_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_i.ready |-> !emit_valid)
    else $error("character request taken while a command is pending");

  a_emit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid && !emit_ready |=> emit_valid)
    else $error("pending command dropped under stall");

  a_scroll_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && (cmd_o.command_kind == CMD_SCROLL) |-> (cmd_o.scroll_rows != '0))
    else $error("scroll request with zero rows");
`endif

endmodule

// File: hw/rtl/tcc_addsub.sv
// Shared adder/subtractor of the cursor sequencer, with carry out (no borrow).
module tcc_addsub #(
  parameter int Width = 14
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic             sub_i,
  output logic [Width-1:0] sum_o,
  output logic             carry_o
);

  logic [Width-1:0] b_op;

  assign b_op = sub_i ? ~b_i : b_i;
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_op} + {{Width{1'b0}}, sub_i};

endmodule

// File: hw/rtl/tcc_seq.sv
// Cursor sequencer: steps each character through the shared adder and emits commands.
module tcc_seq #(
  parameter int COORD_BITS = 12,
  parameter int CELL_BASE  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tcc_pkg::CHAR_BITS-1:0]   char_code_i,
  input  logic [tcc_pkg::STREAM_BITS-1:0] stream_select_i,
  input  tcc_pkg::cfg_t                   cfg_i,
  output logic                           emit_valid_o,
  input  logic                           emit_ready_i,
  output tcc_pkg::cmd_t                   emit_o
);
  import tcc_pkg::*;

  localparam int AW       = (COORD_BITS > SCREEN_BITS ? COORD_BITS : SCREEN_BITS) + 2;
  localparam int CELL_W   = $clog2(CELL_BASE * SCALE_MAX + 1);
  localparam int DIV_BITS = $clog2(SCREEN_BITS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADV1    = 4'd1;
  localparam logic [3:0] S_ADV2    = 4'd2;
  localparam logic [3:0] S_ADV3    = 4'd3;
  localparam logic [3:0] S_NL1     = 4'd4;
  localparam logic [3:0] S_NL2     = 4'd5;
  localparam logic [3:0] S_NL3     = 4'd6;
  localparam logic [3:0] S_NL4     = 4'd7;
  localparam logic [3:0] S_DRAW    = 4'd8;
  localparam logic [3:0] S_SCRL    = 4'd9;
  localparam logic [3:0] S_BS_X    = 4'd10;
  localparam logic [3:0] S_DIV     = 4'd11;
  localparam logic [3:0] S_BS_SUB  = 4'd12;
  localparam logic [3:0] S_BS_WRAP = 4'd13;
  localparam logic [3:0] S_BS_Y    = 4'd14;
  localparam logic [3:0] S_BS_END  = 4'd15;

  logic [3:0]            state_q, state_d;
  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [COORD_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  scroll_q, scroll_d;
  logic                  nl_only_q, nl_only_d;
  logic [AW-1:0]         t_q, t_d, rem_q, rem_d;
  logic [DIV_BITS-1:0]   div_q, div_d;
  logic [CHAR_BITS-1:0]  glyph_q, glyph_d;
  logic [COLOR_BITS-1:0] ink_q, ink_d;

  logic [SCALE_BITS-1:0] scale_eff;
  logic [CELL_W-1:0]     cell_sz;
  logic [ROWS_BITS-1:0]  rows;
  logic [AW-1:0]         cell_w, sw_w, sh_w, rem_sh;
  logic [DIV_BITS-1:0]   bit_idx;
  logic [AW-1:0]         op_a, op_b, sum;
  logic                  op_sub, carry;

  always_comb begin
    if (cfg_i.glyph_scale == '0) begin
      scale_eff = SCALE_BITS'(1);
    end else if (cfg_i.glyph_scale > SCALE_BITS'(SCALE_MAX)) begin
      scale_eff = SCALE_BITS'(SCALE_MAX);
    end else begin
      scale_eff = cfg_i.glyph_scale;
    end
  end

  assign cell_sz = CELL_W'(scale_eff) * CELL_W'(CELL_BASE);
  assign cell_w  = AW'(cell_sz);
  assign rows    = (cell_w > AW'(ROWS_MAX)) ? ROWS_BITS'(ROWS_MAX) : ROWS_BITS'(cell_sz);
  assign sw_w    = AW'(cfg_i.screen_width);
  assign sh_w    = AW'(cfg_i.screen_height);
  assign bit_idx = DIV_BITS'(SCREEN_BITS - 1) - div_q;
  assign rem_sh  = {rem_q[AW-2:0], cfg_i.screen_width[bit_idx]};

  tcc_addsub #(.Width(AW)) u_addsub (
    .a_i     (op_a),
    .b_i     (op_b),
    .sub_i   (op_sub),
    .sum_o   (sum),
    .carry_o (carry)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    cnt_d     = cnt_q;
    scroll_d  = scroll_q;
    nl_only_d = nl_only_q;
    t_d       = t_q;
    rem_d     = rem_q;
    div_d     = div_q;
    glyph_d   = glyph_q;
    ink_d     = ink_q;
    op_a      = '0;
    op_b      = '0;
    op_sub    = 1'b0;

    emit_valid_o        = 1'b0;
    emit_o.command_kind = CMD_DRAW;
    emit_o.glyph_code   = glyph_q;
    emit_o.cell_x       = SCREEN_BITS'(dx_q);
    emit_o.cell_y       = SCREEN_BITS'(dy_q);
    emit_o.draw_color   = ink_q;
    emit_o.scroll_rows  = '0;
    emit_o.last         = (cnt_q == '0) && !scroll_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (stream_select_i inside {STREAM_OUT, STREAM_ERR})) begin
          ink_d     = (stream_select_i == STREAM_OUT) ? cfg_i.ink_color : RED_INK;
          glyph_d   = char_code_i;
          dx_d      = x_q;
          dy_d      = y_q;
          cnt_d     = '0;
          scroll_d  = 1'b0;
          nl_only_d = 1'b0;
          case (char_code_i)
            CH_TAB: begin
              glyph_d = CH_SPACE;
              cnt_d   = CNT_BITS'(TAB_SPACES - 1);
              state_d = S_ADV1;
            end
            CH_BS: begin
              glyph_d = CH_SPACE;
              state_d = S_BS_X;
            end
            CH_NL: begin
              nl_only_d = 1'b1;
              x_d       = '0;
              state_d   = S_NL1;
            end
            default: state_d = S_ADV1;
          endcase
        end
      end
      S_ADV1: begin
        op_a    = AW'(x_q);
        op_b    = cell_w;
        x_d     = sum[COORD_BITS-1:0];
        state_d = S_ADV2;
      end
      S_ADV2: begin
        op_a    = AW'(x_q);
        op_b    = cell_w;
        t_d     = sum;
        state_d = S_ADV3;
      end
      S_ADV3: begin
        op_a   = sw_w;
        op_b   = t_q;
        op_sub = 1'b1;
        if (!carry) begin
          x_d     = '0;
          state_d = S_NL1;
        end else begin
          state_d = S_DRAW;
        end
      end
      S_NL1: begin
        op_a    = AW'(y_q);
        op_b    = cell_w;
        t_d     = sum;
        state_d = S_NL2;
      end
      S_NL2: begin
        op_a    = t_q;
        op_b    = cell_w;
        t_d     = sum;
        state_d = S_NL3;
      end
      S_NL3: begin
        op_a   = t_q;
        op_b   = sh_w;
        op_sub = 1'b1;
        if (carry) begin
          scroll_d = 1'b1;
          state_d  = nl_only_q ? S_SCRL : S_DRAW;
        end else begin
          state_d = S_NL4;
        end
      end
      S_NL4: begin
        op_a    = AW'(y_q);
        op_b    = cell_w;
        y_d     = sum[COORD_BITS-1:0];
        state_d = nl_only_q ? S_IDLE : S_DRAW;
      end
      S_DRAW: begin
        emit_valid_o = 1'b1;
        if (emit_ready_i) begin
          if (scroll_q) begin
            state_d = S_SCRL;
          end else if (cnt_q != '0) begin
            cnt_d   = cnt_q - CNT_BITS'(1);
            dx_d    = x_q;
            dy_d    = y_q;
            state_d = S_ADV1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCRL: begin
        emit_valid_o        = 1'b1;
        emit_o.command_kind = CMD_SCROLL;
        emit_o.glyph_code   = '0;
        emit_o.cell_x       = '0;
        emit_o.cell_y       = '0;
        emit_o.draw_color   = cfg_i.paper_color;
        emit_o.scroll_rows  = rows;
        emit_o.last         = (cnt_q == '0);
        if (emit_ready_i) begin
          scroll_d = 1'b0;
          if (cnt_q != '0) begin
            cnt_d   = cnt_q - CNT_BITS'(1);
            dx_d    = x_q;
            dy_d    = y_q;
            state_d = S_ADV1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_BS_X: begin
        op_a   = AW'(x_q);
        op_b   = cell_w;
        op_sub = 1'b1;
        if (x_q != '0) begin
          x_d     = carry ? sum[COORD_BITS-1:0] : '0;
          state_d = S_BS_END;
        end else if (y_q != '0) begin
          rem_d   = '0;
          div_d   = '0;
          state_d = S_DIV;
        end else begin
          state_d = S_BS_END;
        end
      end
      // remainder of screen width by cell size, one bit a cycle
      S_DIV: begin
        op_a   = rem_sh;
        op_b   = cell_w;
        op_sub = 1'b1;
        rem_d  = carry ? sum : rem_sh;
        div_d  = div_q + DIV_BITS'(1);
        if (div_q == DIV_BITS'(SCREEN_BITS - 1)) begin
          state_d = S_BS_SUB;
        end
      end
      S_BS_SUB: begin
        op_a    = sw_w;
        op_b    = rem_q;
        op_sub  = 1'b1;
        t_d     = sum;
        state_d = S_BS_WRAP;
      end
      S_BS_WRAP: begin
        op_a    = t_q;
        op_b    = cell_w;
        op_sub  = 1'b1;
        x_d     = carry ? sum[COORD_BITS-1:0] : '0;
        state_d = S_BS_Y;
      end
      S_BS_Y: begin
        op_a    = AW'(y_q);
        op_b    = cell_w;
        op_sub  = 1'b1;
        y_d     = carry ? sum[COORD_BITS-1:0] : '0;
        state_d = S_BS_END;
      end
      S_BS_END: begin
        dx_d    = x_q;
        dy_d    = y_q;
        state_d = S_DRAW;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      x_q       <= '0;
      y_q       <= '0;
      cnt_q     <= '0;
      scroll_q  <= 1'b0;
      nl_only_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      x_q       <= x_d;
      y_q       <= y_d;
      cnt_q     <= cnt_d;
      scroll_q  <= scroll_d;
      nl_only_q <= nl_only_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    t_q     <= t_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    glyph_q <= glyph_d;
    ink_q   <= ink_d;
  end

endmodule

// File: bench/console_cmd_checker.sv
// Checker of the text console cursor control: tracks registers and cursor, checks every command.
module console_cmd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcc_char_if         char_mon,
  tcc_cmd_if          cmd_mon,
  tcc_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int CW = COORD_BITS_DEF;

  logic [COLOR_BITS-1:0]  ink_reg;
  logic [COLOR_BITS-1:0]  paper_reg;
  logic [SCALE_BITS-1:0]  scale_reg;
  logic [SCREEN_BITS-1:0] width_reg;
  logic [SCREEN_BITS-1:0] height_reg;
  logic [CW-1:0]          cur_x;
  logic [CW-1:0]          cur_y;
  cmd_t                   queued_cmds[$];
  int unsigned            mismatches;

  task automatic report_cmd(input string why);
    mismatches++;
    $display("[%0t] command mismatch:%s", $time, why);
  endtask

  function automatic int unsigned cell_px();
    int unsigned s;
    s = scale_reg;
    if (s < 1) s = 1;
    if (s > SCALE_MAX) s = SCALE_MAX;
    return s * CELL_BASE_DEF;
  endfunction

  function automatic void push_cmd(input logic kind, input logic [CHAR_BITS-1:0] glyph,
                                   input int unsigned x, input int unsigned y,
                                   input logic [COLOR_BITS-1:0] color,
                                   input int unsigned rows);
    cmd_t c;
    c.command_kind = kind;
    c.glyph_code   = glyph;
    c.cell_x       = SCREEN_BITS'(x);
    c.cell_y       = SCREEN_BITS'(y);
    c.draw_color   = color;
    c.scroll_rows  = ROWS_BITS'(rows);
    c.last         = 1'b0;
    queued_cmds.push_back(c);
  endfunction

  // carriage return plus line feed; scrolls instead when too near the bottom
  function automatic void line_feed();
    int unsigned csz;
    csz = cell_px();
    cur_x = '0;
    if (cur_y + 2 * csz >= height_reg)
      push_cmd(CMD_SCROLL, '0, 0, 0, paper_reg, (csz > ROWS_MAX) ? ROWS_MAX : csz);
    else
      cur_y = CW'(cur_y + csz);
  endfunction

  function automatic void step_right();
    int unsigned csz;
    csz = cell_px();
    cur_x = CW'(cur_x + csz);
    if (cur_x + csz > width_reg) line_feed();
  endfunction

  function automatic void step_back(input logic [COLOR_BITS-1:0] ink);
    int unsigned csz;
    int unsigned cols;
    csz = cell_px();
    if (cur_x != 0) begin
      cur_x = (cur_x >= csz) ? CW'(cur_x - csz) : '0;
    end else if (cur_y != 0) begin
      cols  = width_reg / csz;
      cur_x = (cols > 0) ? CW'((cols - 1) * csz) : '0;
      cur_y = (cur_y >= csz) ? CW'(cur_y - csz) : '0;
    end
    push_cmd(CMD_DRAW, CH_SPACE, cur_x, cur_y, ink, 0);
  endfunction

  function automatic void render_char(input logic [CHAR_BITS-1:0] code,
                                      input logic [STREAM_BITS-1:0] stream);
    logic [COLOR_BITS-1:0] ink;
    int unsigned           first;
    cmd_t                  tail;
    if (stream == STREAM_OUT) ink = ink_reg;
    else if (stream == STREAM_ERR) ink = RED_INK;
    else return;
    first = queued_cmds.size();
    if (code == CH_TAB) begin
      for (int i = 0; i < TAB_SPACES; i++) begin
        push_cmd(CMD_DRAW, CH_SPACE, cur_x, cur_y, ink, 0);
        step_right();
      end
    end else if (code == CH_BS) begin
      step_back(ink);
    end else if (code == CH_NL) begin
      line_feed();
    end else begin
      push_cmd(CMD_DRAW, code, cur_x, cur_y, ink, 0);
      step_right();
    end
    if (queued_cmds.size() > first) begin
      tail = queued_cmds.pop_back();
      tail.last = 1'b1;
      queued_cmds.push_back(tail);
    end
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_INK:    ink_reg    = data[COLOR_BITS-1:0];
      REG_PAPER:  paper_reg  = data[COLOR_BITS-1:0];
      REG_SCALE:  scale_reg  = data[SCALE_BITS-1:0];
      REG_WIDTH:  width_reg  = data[SCREEN_BITS-1:0];
      REG_HEIGHT: height_reg = data[SCREEN_BITS-1:0];
      default: ;
    endcase
  endfunction

  task automatic compare_cmd(input cmd_t got, input cmd_t want);
    string diffs;
    diffs = "";
    if (got.command_kind !== want.command_kind)
      diffs = {diffs, $sformatf(" kind %0h/%0h", got.command_kind, want.command_kind)};
    if (got.glyph_code !== want.glyph_code)
      diffs = {diffs, $sformatf(" glyph %0h/%0h", got.glyph_code, want.glyph_code)};
    if (got.cell_x !== want.cell_x)
      diffs = {diffs, $sformatf(" x %0d/%0d", got.cell_x, want.cell_x)};
    if (got.cell_y !== want.cell_y)
      diffs = {diffs, $sformatf(" y %0d/%0d", got.cell_y, want.cell_y)};
    if (got.draw_color !== want.draw_color)
      diffs = {diffs, $sformatf(" colour %06h/%06h", got.draw_color, want.draw_color)};
    if (got.scroll_rows !== want.scroll_rows)
      diffs = {diffs, $sformatf(" rows %0d/%0d", got.scroll_rows, want.scroll_rows)};
    if (got.last !== want.last)
      diffs = {diffs, $sformatf(" last %0h/%0h", got.last, want.last)};
    if (diffs != "") report_cmd({diffs, " (got/exp)"});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t got;
    if (!rst_ni) begin
      ink_reg    = 24'hFFFFFF;
      paper_reg  = '0;
      scale_reg  = 5'd1;
      width_reg  = 12'd1024;
      height_reg = 12'd768;
      cur_x      = '0;
      cur_y      = '0;
      queued_cmds.delete();
      mismatches = 0;
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      // results first: a command taken now never belongs to a character taken now
      if (cmd_mon.valid && cmd_mon.ready) begin
        got.command_kind = cmd_mon.command_kind;
        got.glyph_code   = cmd_mon.glyph_code;
        got.cell_x       = cmd_mon.cell_x;
        got.cell_y       = cmd_mon.cell_y;
        got.draw_color   = cmd_mon.draw_color;
        got.scroll_rows  = cmd_mon.scroll_rows;
        got.last         = cmd_mon.last;
        if (queued_cmds.size() == 0) report_cmd(" command with none outstanding");
        else compare_cmd(got, queued_cmds.pop_front());
      end
      if (cfg_mon.valid && cfg_mon.ready) write_reg(cfg_mon.index, cfg_mon.data);
      if (char_mon.valid && char_mon.ready)
        render_char(char_mon.char_code, char_mon.stream_select);
      fail_count    <= mismatches;
      pending_count <= queued_cmds.size();
    end
  end

endmodule

// File: bench/tb_text_console_cursor_control.sv
// Testbench top of the text console cursor control: clock, reset, stimulus and verdict.
module tb_text_console_cursor_control;

  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RAND_PHASES     = 11;
  localparam int ITEMS_PER_PHASE = 25;

  logic        clk_i;
  logic        rst_ni;
  bit          idle_on;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned pending_count;

  tcc_char_if char_if ();
  tcc_cmd_if  cmd_if ();
  tcc_cfg_if  cfg_if ();

  text_console_cursor_control i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .cmd_o  (cmd_if),
    .cfg_i  (cfg_if)
  );

  console_cmd_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_mon      (char_if),
    .cmd_mon       (cmd_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // command sink: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (!idle_on) begin
      cmd_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      cmd_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      cmd_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 10);
    end else begin
      cmd_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (char_if.valid && char_if.ready) || (cmd_if.valid && cmd_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [CHAR_BITS-1:0] code,
                           input logic [STREAM_BITS-1:0] stream);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid         <= 1'b1;
    char_if.char_code     <= code;
    char_if.stream_select <= stream;
    do @(posedge clk_i); while (!char_if.ready);
  endtask

  // wait for every outstanding command, then let a silent request finish
  task automatic drain();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic program_regs(input logic [COLOR_BITS-1:0] ink,
                              input logic [COLOR_BITS-1:0] paper,
                              input logic [SCALE_BITS-1:0] scale,
                              input logic [SCREEN_BITS-1:0] wid,
                              input logic [SCREEN_BITS-1:0] hgt,
                              input bit spare);
    drain();
    cfg_put(REG_INK, ink);
    cfg_put(REG_PAPER, paper);
    cfg_put(REG_SCALE, CFG_DATA_BITS'(scale));
    cfg_put(REG_WIDTH, CFG_DATA_BITS'(wid));
    cfg_put(REG_HEIGHT, CFG_DATA_BITS'(hgt));
    // unused indexes must be ignored
    if (spare)
      for (int k = REG_HEIGHT + 1; k < 2 ** CFG_IDX_BITS; k++)
        cfg_put(CFG_IDX_BITS'(k), CFG_DATA_BITS'($urandom()));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    char_if.valid         = 1'b0;
    char_if.char_code     = '0;
    char_if.stream_select = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    idle_on               = 1'b1;
    rst_ni                = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: glyphs, red ink, tab, backspace both ways, quiet newline, ignored streams
    send_char("A", STREAM_OUT);
    send_char(8'h00, STREAM_ERR);
    send_char(8'hFF, STREAM_OUT);
    send_char(CH_TAB, STREAM_ERR);
    send_char(CH_BS, STREAM_OUT);
    send_char(CH_NL, STREAM_OUT);
    send_char(CH_BS, STREAM_ERR);
    send_char("z", 2'd2);
    send_char(8'hAA, 2'd3);

    // tiny screen, scale 0 read as 1: right-edge wrap and scrolling
    program_regs(24'h000000, 24'hFFFFFF, 5'd0, 12'd40, 12'd24, 1'b0);
    send_char("a", STREAM_OUT);
    send_char("b", STREAM_ERR);
    send_char("c", STREAM_OUT);
    send_char("d", STREAM_OUT);
    send_char("e", STREAM_OUT);
    send_char(CH_NL, STREAM_ERR);
    send_char(CH_TAB, STREAM_OUT);

    // scale above the maximum, screen narrower than one cell: backspace clamps at 0
    program_regs(24'h5A5A5A, 24'hA5A5A5, 5'd31, 12'd8, 12'd4095, 1'b1);
    send_char(CH_BS, STREAM_OUT);
    send_char(CH_NL, STREAM_OUT);
    send_char(CH_BS, STREAM_ERR);
    send_char("q", STREAM_OUT);
    send_char(CH_NL, STREAM_OUT);

    for (int p = 0; p < RAND_PHASES; p++) begin
      logic [SCALE_BITS-1:0]  scale;
      logic [SCREEN_BITS-1:0] wid;
      logic [SCREEN_BITS-1:0] hgt;
      if (p == 0) begin
        program_regs(24'hFFFFFF, 24'h000000, 5'd16, 12'd4095, 12'd4095, 1'b0);
      end else if (p == 1) begin
        program_regs(24'h000000, 24'hFFFFFF, 5'd1, 12'd8, 12'd8, 1'b0);
      end else begin
        scale = ($urandom_range(0, 3) == 0) ? SCALE_BITS'($urandom_range(0, 31))
                                            : SCALE_BITS'($urandom_range(1, 4));
        wid = ($urandom_range(0, 4) == 0) ? SCREEN_BITS'($urandom_range(8, 4095))
                                          : SCREEN_BITS'($urandom_range(8, 400));
        hgt = ($urandom_range(0, 4) == 0) ? SCREEN_BITS'($urandom_range(8, 4095))
                                          : SCREEN_BITS'($urandom_range(8, 200));
        program_regs(COLOR_BITS'($urandom()), COLOR_BITS'($urandom()), scale, wid, hgt,
                     p == 2);
      end
      idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        int unsigned           roll;
        logic [CHAR_BITS-1:0]   code;
        logic [STREAM_BITS-1:0] stream;
        roll = $urandom_range(0, 99);
        if (roll < 15) code = CH_TAB;
        else if (roll < 30) code = CH_BS;
        else if (roll < 50) code = CH_NL;
        else code = CHAR_BITS'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 45) stream = STREAM_OUT;
        else if (roll < 90) stream = STREAM_ERR;
        else stream = STREAM_BITS'($urandom_range(2, 3));
        send_char(code, stream);
      end
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
